/* design/apfp_pkg.sv */
// Package: shared constants and types of the ASCII position frame parser.
package apfp_pkg;

   localparam int FrameLenDefault = 32;

   // Result status codes
   typedef enum logic [2:0] {
      ST_IGNORED  = 3'd0,
      ST_STORED   = 3'd1,
      ST_VALID    = 3'd2,
      ST_FORMAT   = 3'd3,
      ST_CHECKSUM = 3'd4,
      ST_RANGE    = 3'd5,
      ST_OVERFLOW = 3'd6
   } status_type;

   // Register indexes
   localparam logic REG_POS_MIN = 1'b0;
   localparam logic REG_POS_MAX = 1'b1;

   localparam logic [7:0] CH_OPEN  = 8'h28;
   localparam logic [7:0] CH_CLOSE = 8'h29;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_AT    = 8'h40;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] PRINT_LO = 8'h20;
   localparam logic [7:0] PRINT_HI = 8'h7E;

   localparam logic [32:0] MAG_CAP = 33'h1_0000_0000 >> 1;

   // Result word toward the output register
   typedef struct packed {
      status_type  status;
      logic        data_valid;
      logic [31:0] position;
      logic [31:0] velocity;
      logic [31:0] frames_seen;
      logic [31:0] frames_good;
      logic [31:0] format_error_count;
      logic [31:0] checksum_error_count;
      logic [31:0] range_error_count;
      logic [31:0] overflow_error_count;
      logic [7:0]  computed_sum;
      logic [7:0]  sent_sum;
   } result_type;

   function automatic logic is_digit(input logic [6:0] c);
      return (c >= 7'h30) && (c <= 7'h39);
   endfunction

   function automatic logic is_hex(input logic [6:0] c);
      return is_digit(c) || ((c >= 7'h41) && (c <= 7'h46)) ||
             ((c >= 7'h61) && (c <= 7'h66));
   endfunction

   function automatic logic [3:0] hex_val(input logic [6:0] c);
      logic [3:0] v;
      v = 4'd0;
      if (is_digit(c))
         v = c[3:0];
      else
         v = c[3:0] + 4'd9;
      return v;
   endfunction

endpackage

/* design/apfp_scan.sv */
// Frame scanner: buffers frame characters and rescans them at the closing byte.
module apfp_scan #(
   parameter int FRAME_LEN = apfp_pkg::FrameLenDefault
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [7:0]               req_rx_byte,
   input  logic signed [31:0]       pos_min,
   input  logic signed [31:0]       pos_max,
   output logic                     res_valid,
   input  logic                     res_stall,
   output apfp_pkg::result_type     res_word
);
   import apfp_pkg::*;

   localparam int AW = $clog2(FRAME_LEN);
   localparam int LW = $clog2(FRAME_LEN + 1);

   // Event counter slots
   localparam int CNT_SEEN     = 0;
   localparam int CNT_GOOD     = 1;
   localparam int CNT_FORMAT   = 2;
   localparam int CNT_CHECKSUM = 3;
   localparam int CNT_RANGE    = 4;
   localparam int CNT_OVERFLOW = 5;

   typedef enum logic [2:0] {
      S_IDLE, S_FIND, S_SUM, S_FLD, S_EVAL, S_OUT
   } state_type;

   // Character store: one write port, one registered read port
   logic [6:0] store_mem [FRAME_LEN];
   logic [6:0] rd_data_ff;
   logic       wr_en;
   logic [AW-1:0] wr_addr, rd_addr;

   state_type  state_ff;
   logic       in_frame_ff;
   logic [LW-1:0] len_ff;
   logic [LW-1:0] idx_ff;       // read address now on the port
   logic       rd_ok_ff;        // rd_data_ff belongs to idx_ff-1
   logic [6:0] prev_ff;
   logic [LW-1:0] mark_ff;
   logic       found_ff;
   logic [6:0] hex_hi_ff, hex_lo_ff;
   logic [7:0] sum_ff;
   // field parse
   logic       fld_ff;          // 0 position, 1 velocity
   logic [1:0] ph_ff;           // 0 sign,1 int,2 frac
   logic       neg_ff, got_ff;
   logic [32:0] ip_ff;
   logic [9:0]  fr_ff;
   logic [1:0]  fcnt_ff;
   logic signed [32:0] pos_ff;
   logic [1:0]  mul_ff;
   logic [43:0] magw_ff;

   logic        last_valid_ff;
   logic [31:0] last_pos_ff, last_vel_ff;
   logic [31:0] vel_out_ff;     // committed velocity; last_vel_ff is written early
   logic [31:0] cnt_ff [6];
   logic [7:0]  csum_ff, ssum_ff;
   status_type  status_ff;
   logic        res_valid_ff;
   result_type  w;

   logic [6:0] ch;
   assign ch = rd_data_ff;

   // Memory
   always_ff @(posedge clock) begin
      if (wr_en) store_mem[wr_addr] <= req_rx_byte[6:0];
      rd_data_ff <= store_mem[rd_addr];
   end

   assign wr_en   = (state_ff == S_IDLE) && req_valid && in_frame_ff &&
                    req_rx_byte != CH_OPEN && req_rx_byte != CH_CLOSE &&
                    req_rx_byte >= PRINT_LO && req_rx_byte <= PRINT_HI &&
                    len_ff < LW'(FRAME_LEN - 1);
   assign wr_addr = len_ff[AW-1:0];
   assign rd_addr = idx_ff[AW-1:0];
   assign req_stall = (state_ff != S_IDLE);
   assign res_valid = res_valid_ff;

   // Magnitude from integer and fraction, then saturate
   logic [43:0] mag_full;
   assign mag_full = magw_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         in_frame_ff <= 1'b0;
         len_ff <= '0;
         idx_ff <= '0;
         rd_ok_ff <= 1'b0;
         last_valid_ff <= 1'b0;
         last_pos_ff <= '0;
         last_vel_ff <= '0;
         vel_out_ff <= '0;
         for (int k = 0; k < 6; k++) cnt_ff[k] <= '0;
         csum_ff <= '0;
         ssum_ff <= '0;
         res_valid_ff <= 1'b0;
         status_ff <= ST_IGNORED;
      end else begin
         if (res_valid_ff && !res_stall) res_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  state_ff <= S_OUT;
                  if (req_rx_byte == CH_OPEN) begin
                     status_ff <= ST_STORED;
                     if (in_frame_ff && len_ff != '0) begin
                        cnt_ff[CNT_FORMAT] <= cnt_ff[CNT_FORMAT] + 32'd1;
                        status_ff <= ST_FORMAT;
                     end
                     len_ff <= '0;
                     in_frame_ff <= 1'b1;
                  end else if (!in_frame_ff) begin
                     status_ff <= ST_IGNORED;
                  end else if (req_rx_byte == CH_CLOSE) begin
                     in_frame_ff <= 1'b0;
                     if (len_ff == '0) begin
                        cnt_ff[CNT_FORMAT] <= cnt_ff[CNT_FORMAT] + 32'd1;
                        last_valid_ff <= 1'b0;
                        status_ff <= ST_FORMAT;
                     end else begin
                        cnt_ff[CNT_SEEN] <= cnt_ff[CNT_SEEN] + 32'd1;
                        last_valid_ff <= 1'b0;
                        found_ff <= 1'b0;
                        idx_ff <= '0;
                        rd_ok_ff <= 1'b0;
                        prev_ff <= '0;
                        state_ff <= S_FIND;
                     end
                  end else if (req_rx_byte == CH_CR || req_rx_byte == CH_LF ||
                               req_rx_byte < PRINT_LO || req_rx_byte > PRINT_HI) begin
                     cnt_ff[CNT_FORMAT] <= cnt_ff[CNT_FORMAT] + 32'd1;
                     last_valid_ff <= 1'b0;
                     len_ff <= '0;
                     in_frame_ff <= 1'b0;
                     status_ff <= ST_FORMAT;
                  end else if (!wr_en) begin
                     cnt_ff[CNT_OVERFLOW] <= cnt_ff[CNT_OVERFLOW] + 32'd1;
                     last_valid_ff <= 1'b0;
                     len_ff <= '0;
                     in_frame_ff <= 1'b0;
                     status_ff <= ST_OVERFLOW;
                  end else begin
                     len_ff <= len_ff + LW'(1);
                     status_ff <= ST_STORED;
                  end
               end
            end
            // Find the last ",@" and capture the last two chars of the buffer
            S_FIND: begin
               if (idx_ff < len_ff) begin
                  idx_ff <= idx_ff + LW'(1);
                  rd_ok_ff <= 1'b1;
               end else begin
                  rd_ok_ff <= 1'b0;
               end
               if (rd_ok_ff) begin
                  prev_ff <= ch;
                  if (prev_ff == CH_COMMA[6:0] && ch == CH_AT[6:0] && idx_ff >= LW'(2)) begin
                     found_ff <= 1'b1;
                     mark_ff <= idx_ff - LW'(2);
                  end
                  if (idx_ff == len_ff - LW'(1)) hex_hi_ff <= ch;
                  if (idx_ff == len_ff) hex_lo_ff <= ch;
               end
               if (rd_ok_ff && idx_ff == len_ff) begin
                  // checks after the whole buffer was seen
                  if (!(found_ff || (prev_ff == CH_COMMA[6:0] && ch == CH_AT[6:0]))) begin
                     cnt_ff[CNT_FORMAT] <= cnt_ff[CNT_FORMAT] + 32'd1;
                     status_ff <= ST_FORMAT;
                     state_ff <= S_OUT;
                  end else begin
                     state_ff <= S_SUM;
                     idx_ff <= '0;
                     rd_ok_ff <= 1'b0;
                     sum_ff <= '0;
                  end
               end
            end
            S_SUM: begin
               if (!(LW'(mark_ff + LW'(4)) == len_ff && len_ff >= LW'(4)) ||
                   !is_hex(hex_hi_ff) || !is_hex(hex_lo_ff)) begin
                  cnt_ff[CNT_FORMAT] <= cnt_ff[CNT_FORMAT] + 32'd1;
                  status_ff <= ST_FORMAT;
                  state_ff <= S_OUT;
               end else begin
                  if (idx_ff < mark_ff) begin
                     idx_ff <= idx_ff + LW'(1);
                     rd_ok_ff <= 1'b1;
                  end else begin
                     rd_ok_ff <= 1'b0;
                  end
                  if (rd_ok_ff) sum_ff <= sum_ff + {1'b0, ch};
                  if ((rd_ok_ff && idx_ff == mark_ff) || mark_ff == '0) begin
                     csum_ff <= sum_ff + (rd_ok_ff ? {1'b0, ch} : 8'd0);
                     ssum_ff <= {hex_val(hex_hi_ff), hex_val(hex_lo_ff)};
                     if ((sum_ff + (rd_ok_ff ? {1'b0, ch} : 8'd0)) !=
                         {hex_val(hex_hi_ff), hex_val(hex_lo_ff)}) begin
                        cnt_ff[CNT_CHECKSUM] <= cnt_ff[CNT_CHECKSUM] + 32'd1;
                        status_ff <= ST_CHECKSUM;
                        state_ff <= S_OUT;
                     end else begin
                        state_ff <= S_FLD;
                        idx_ff <= '0;
                        rd_ok_ff <= 1'b0;
                        fld_ff <= 1'b0;
                        ph_ff <= 2'd0;
                        got_ff <= 1'b0;
                        ip_ff <= '0;
                        fr_ff <= '0;
                        fcnt_ff <= '0;
                        mul_ff <= '0;
                     end
                  end
               end
            end
            // Parse both decimals; a character is read only once the previous one has been taken
            S_FLD: begin
               if (mul_ff != 2'd0) begin
                  // finish field: scale into magw_ff, then saturate
                  if (mul_ff == 2'd1) begin
                     magw_ff <= 44'(ip_ff) * 44'd1000 + 44'(fr_ff);
                     mul_ff <= 2'd2;
                  end else begin
                     logic [32:0] m;
                     m = (mag_full > 44'(MAG_CAP)) ? MAG_CAP : mag_full[32:0];
                     if (!neg_ff && m > MAG_CAP - 33'd1) m = MAG_CAP - 33'd1;
                     mul_ff <= 2'd0;
                     if (fld_ff == 1'b0) begin
                        pos_ff <= neg_ff ? -$signed(m) : $signed(m);
                        fld_ff <= 1'b1;
                        ph_ff <= 2'd0;
                        got_ff <= 1'b0;
                        ip_ff <= '0;
                        fr_ff <= '0;
                        fcnt_ff <= '0;
                        idx_ff <= idx_ff;
                     end else begin
                        last_vel_ff <= neg_ff ? 32'(-$signed(m)) : m[31:0];
                        state_ff <= S_EVAL;
                     end
                  end
               end else begin
                  if (idx_ff < mark_ff && !rd_ok_ff) begin
                     idx_ff <= idx_ff + LW'(1);
                     rd_ok_ff <= 1'b1;
                  end else if (rd_ok_ff) begin
                     rd_ok_ff <= 1'b0;
                  end
                  if (rd_ok_ff || (idx_ff == mark_ff && !rd_ok_ff)) begin
                     logic endf;
                     endf = !rd_ok_ff || (ch == CH_COMMA[6:0]);
                     if (endf) begin
                        if (ph_ff != 2'd2 || !got_ff ||
                            (fld_ff == 1'b0 && !rd_ok_ff) ||
                            (fld_ff == 1'b1 && rd_ok_ff)) begin
                           cnt_ff[CNT_FORMAT] <= cnt_ff[CNT_FORMAT] + 32'd1;
                           status_ff <= ST_FORMAT;
                           state_ff <= S_OUT;
                        end else begin
                           mul_ff <= 2'd1;
                        end
                     end else if (ph_ff == 2'd0) begin
                        if (ch == CH_PLUS[6:0] || ch == CH_MINUS[6:0]) begin
                           neg_ff <= (ch == CH_MINUS[6:0]);
                           ph_ff <= 2'd1;
                        end else begin
                           cnt_ff[CNT_FORMAT] <= cnt_ff[CNT_FORMAT] + 32'd1;
                           status_ff <= ST_FORMAT;
                           state_ff <= S_OUT;
                        end
                     end else if (ph_ff == 2'd1) begin
                        if (is_digit(ch)) begin
                           logic [36:0] t;
                           t = 37'(ip_ff) * 37'd10 + 37'(ch[3:0]);
                           ip_ff <= (t > 37'(MAG_CAP)) ? MAG_CAP : t[32:0];
                           got_ff <= 1'b1;
                        end else if (ch == CH_DOT[6:0] && got_ff) begin
                           ph_ff <= 2'd2;
                           got_ff <= 1'b0;
                        end else begin
                           cnt_ff[CNT_FORMAT] <= cnt_ff[CNT_FORMAT] + 32'd1;
                           status_ff <= ST_FORMAT;
                           state_ff <= S_OUT;
                        end
                     end else begin
                        if (is_digit(ch)) begin
                           got_ff <= 1'b1;
                           if (fcnt_ff != 2'd3) begin
                              fcnt_ff <= fcnt_ff + 2'd1;
                              case (fcnt_ff)
                                 2'd0: fr_ff <= fr_ff + 10'(ch[3:0]) * 10'd100;
                                 2'd1: fr_ff <= fr_ff + 10'(ch[3:0]) * 10'd10;
                                 default: fr_ff <= fr_ff + 10'(ch[3:0]);
                              endcase
                           end
                        end else begin
                           cnt_ff[CNT_FORMAT] <= cnt_ff[CNT_FORMAT] + 32'd1;
                           status_ff <= ST_FORMAT;
                           state_ff <= S_OUT;
                        end
                     end
                  end
               end
            end
            S_EVAL: begin
               if (pos_ff < 33'(pos_min) || pos_ff > 33'(pos_max)) begin
                  cnt_ff[CNT_RANGE] <= cnt_ff[CNT_RANGE] + 32'd1;
                  status_ff <= ST_RANGE;
                  last_vel_ff <= last_vel_ff;
               end else begin
                  last_pos_ff <= pos_ff[31:0];
                  vel_out_ff <= last_vel_ff;
                  cnt_ff[CNT_GOOD] <= cnt_ff[CNT_GOOD] + 32'd1;
                  last_valid_ff <= 1'b1;
                  status_ff <= ST_VALID;
               end
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (!res_valid_ff || !res_stall) begin
                  res_valid_ff <= 1'b1;
                  res_word <= w;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   always_comb begin
      w.status = status_ff;
      w.data_valid = last_valid_ff;
      w.position = last_pos_ff;
      w.velocity = vel_out_ff;
      w.frames_seen = cnt_ff[CNT_SEEN];
      w.frames_good = cnt_ff[CNT_GOOD];
      w.format_error_count = cnt_ff[CNT_FORMAT];
      w.checksum_error_count = cnt_ff[CNT_CHECKSUM];
      w.range_error_count = cnt_ff[CNT_RANGE];
      w.overflow_error_count = cnt_ff[CNT_OVERFLOW];
      w.computed_sum = csum_ff;
      w.sent_sum = ssum_ff;
   end

   assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> req_stall) else $error("input taken while busy");
   assert property (@(posedge clock) disable iff (reset)
      (len_ff < LW'(FRAME_LEN))) else $error("frame length beyond store");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SUM) |=> !in_frame_ff) else $error("frame open during rescan");
endmodule

/* design/ascii_position_frame_parser.sv */
// Top level: ASCII position frame parser with configuration registers.
// One byte word is taken at a time. A plain byte gives its result word through the S_OUT
// state, and the next byte is taken once that word is registered. A closing ')' rescans
// the character store through its single read port: the marker search, the checksum pass,
// the field parse (each character read only after the last one is taken, and a scale step
// then a saturate step per field), then the range check and the output state, which gives
// the result word for the frame. The default store has 32 entries. Frames that fail an
// earlier check return sooner; a stalled result side adds its stall cycles.
module ascii_position_frame_parser #(
   parameter int FRAME_LEN = apfp_pkg::FrameLenDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic        rsp_data_valid,
   output logic signed [31:0] rsp_position,
   output logic signed [31:0] rsp_velocity,
   output logic [31:0] rsp_frames_seen,
   output logic [31:0] rsp_frames_good,
   output logic [31:0] rsp_format_error_count,
   output logic [31:0] rsp_checksum_error_count,
   output logic [31:0] rsp_range_error_count,
   output logic [31:0] rsp_overflow_error_count,
   output logic [7:0]  rsp_computed_sum,
   output logic [7:0]  rsp_sent_sum,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:2]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import apfp_pkg::*;

   logic signed [31:0] pos_min_ff, pos_max_ff;
   result_type word;

   // Configuration registers
   assign pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_min_ff <= 32'sd0;
         pos_max_ff <= 32'sd1000000;
      end else if (psel && penable && pwrite) begin
         unique case (paddr[2])
            REG_POS_MIN: pos_min_ff <= pwdata;
            REG_POS_MAX: pos_max_ff <= pwdata;
            default: ;
         endcase
      end
   end
   assign prdata = (paddr[2] == REG_POS_MAX) ? pos_max_ff : pos_min_ff;

   apfp_scan #(.FRAME_LEN(FRAME_LEN)) u_scan (
      .clock, .reset, .req_valid, .req_stall, .req_rx_byte,
      .pos_min(pos_min_ff), .pos_max(pos_max_ff),
      .res_valid(rsp_valid), .res_stall(rsp_stall), .res_word(word)
   );

   assign rsp_status = word.status;
   assign rsp_data_valid = word.data_valid;
   assign rsp_position = word.position;
   assign rsp_velocity = word.velocity;
   assign rsp_frames_seen = word.frames_seen;
   assign rsp_frames_good = word.frames_good;
   assign rsp_format_error_count = word.format_error_count;
   assign rsp_checksum_error_count = word.checksum_error_count;
   assign rsp_range_error_count = word.range_error_count;
   assign rsp_overflow_error_count = word.overflow_error_count;
   assign rsp_computed_sum = word.computed_sum;
   assign rsp_sent_sum = word.sent_sum;
endmodule
